// ===== rtl/plsimp_pkg.sv =====
// Package for the polyline simplifier: payload structs, controller commands,
// datapath status and fixed arithmetic widths. Depends on nothing.
package plsimp_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int TOL_W   = 16;
    localparam int TOL2_W  = 2 * TOL_W;
    localparam int MUL_W   = 36;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int MIN_POINTS = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      is_last;
    } t_point_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] kept_x;
        logic signed [COORD_W-1:0] kept_y;
        logic                      final_point;
        logic                      overflowed;
    } t_kept_out;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_POP, OP_SPAN, OP_RDS, OP_RDE, OP_TSQ,
        OP_L1, OP_L2, OP_L3, OP_L4, OP_L5, OP_P0, OP_P1, OP_P2, OP_P3, OP_P4,
        OP_P5, OP_PUSH_LO, OP_PUSH_HI, OP_SCAN, OP_FLUSH
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_INIT, ST_POP, ST_SPAN, ST_RDS, ST_RDE, ST_TSQ,
        ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_P0, ST_P1, ST_P2, ST_P3, ST_P4,
        ST_P5, ST_PUSH_LO, ST_PUSH_HI, ST_SCAN, ST_FLUSH
    } t_state;

    typedef struct packed {
        logic pass;
        logic stack_empty;
        logic span_short;
        logic degen;
        logic more;
        logic found;
        logic scan_done;
    } t_status;

endpackage

// ===== rtl/plsimp_ctrl.sv =====
// Sequencer for the polyline simplifier: load, span search and emission.
// Depends on plsimp_pkg.
module plsimp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_is_last,
    input  plsimp_pkg::t_status i_status,
    output plsimp_pkg::t_op    o_op,
    output logic               o_busy
);

    plsimp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plsimp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            plsimp_pkg::ST_IDLE:    if (i_start && i_is_last) n_state = plsimp_pkg::ST_INIT;
            plsimp_pkg::ST_INIT:    n_state = i_status.pass ? plsimp_pkg::ST_SCAN
                                                            : plsimp_pkg::ST_POP;
            plsimp_pkg::ST_POP:     n_state = i_status.stack_empty ? plsimp_pkg::ST_SCAN
                                                                   : plsimp_pkg::ST_SPAN;
            plsimp_pkg::ST_SPAN:    n_state = i_status.span_short ? plsimp_pkg::ST_POP
                                                                  : plsimp_pkg::ST_RDS;
            plsimp_pkg::ST_RDS:     n_state = plsimp_pkg::ST_RDE;
            plsimp_pkg::ST_RDE:     n_state = plsimp_pkg::ST_TSQ;
            plsimp_pkg::ST_TSQ:     n_state = plsimp_pkg::ST_L1;
            plsimp_pkg::ST_L1:      n_state = plsimp_pkg::ST_L2;
            plsimp_pkg::ST_L2:      n_state = plsimp_pkg::ST_L3;
            plsimp_pkg::ST_L3:      n_state = plsimp_pkg::ST_L4;
            plsimp_pkg::ST_L4:      n_state = plsimp_pkg::ST_L5;
            plsimp_pkg::ST_L5:      n_state = plsimp_pkg::ST_P0;
            plsimp_pkg::ST_P0:      n_state = plsimp_pkg::ST_P1;
            plsimp_pkg::ST_P1:      n_state = plsimp_pkg::ST_P2;
            plsimp_pkg::ST_P2:      n_state = plsimp_pkg::ST_P3;
            plsimp_pkg::ST_P3:      n_state = i_status.degen ? plsimp_pkg::ST_P5
                                                             : plsimp_pkg::ST_P4;
            plsimp_pkg::ST_P4:      n_state = plsimp_pkg::ST_P5;
            plsimp_pkg::ST_P5:      n_state = i_status.more ? plsimp_pkg::ST_P0
                                                            : plsimp_pkg::ST_PUSH_LO;
            plsimp_pkg::ST_PUSH_LO: n_state = i_status.found ? plsimp_pkg::ST_PUSH_HI
                                                             : plsimp_pkg::ST_POP;
            plsimp_pkg::ST_PUSH_HI: n_state = plsimp_pkg::ST_POP;
            plsimp_pkg::ST_SCAN:    if (i_status.scan_done) n_state = plsimp_pkg::ST_FLUSH;
            plsimp_pkg::ST_FLUSH:   n_state = plsimp_pkg::ST_IDLE;
            default:                n_state = plsimp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != plsimp_pkg::ST_IDLE);
        unique case (r_state)
            plsimp_pkg::ST_IDLE:    o_op = i_start ? plsimp_pkg::OP_LOAD : plsimp_pkg::OP_NONE;
            plsimp_pkg::ST_INIT:    o_op = plsimp_pkg::OP_INIT;
            plsimp_pkg::ST_POP:     o_op = plsimp_pkg::OP_POP;
            plsimp_pkg::ST_SPAN:    o_op = plsimp_pkg::OP_SPAN;
            plsimp_pkg::ST_RDS:     o_op = plsimp_pkg::OP_RDS;
            plsimp_pkg::ST_RDE:     o_op = plsimp_pkg::OP_RDE;
            plsimp_pkg::ST_TSQ:     o_op = plsimp_pkg::OP_TSQ;
            plsimp_pkg::ST_L1:      o_op = plsimp_pkg::OP_L1;
            plsimp_pkg::ST_L2:      o_op = plsimp_pkg::OP_L2;
            plsimp_pkg::ST_L3:      o_op = plsimp_pkg::OP_L3;
            plsimp_pkg::ST_L4:      o_op = plsimp_pkg::OP_L4;
            plsimp_pkg::ST_L5:      o_op = plsimp_pkg::OP_L5;
            plsimp_pkg::ST_P0:      o_op = plsimp_pkg::OP_P0;
            plsimp_pkg::ST_P1:      o_op = plsimp_pkg::OP_P1;
            plsimp_pkg::ST_P2:      o_op = plsimp_pkg::OP_P2;
            plsimp_pkg::ST_P3:      o_op = plsimp_pkg::OP_P3;
            plsimp_pkg::ST_P4:      o_op = plsimp_pkg::OP_P4;
            plsimp_pkg::ST_P5:      o_op = plsimp_pkg::OP_P5;
            plsimp_pkg::ST_PUSH_LO: o_op = plsimp_pkg::OP_PUSH_LO;
            plsimp_pkg::ST_PUSH_HI: o_op = plsimp_pkg::OP_PUSH_HI;
            plsimp_pkg::ST_SCAN:    o_op = plsimp_pkg::OP_SCAN;
            plsimp_pkg::ST_FLUSH:   o_op = plsimp_pkg::OP_FLUSH;
            default:                o_op = plsimp_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== rtl/plsimp_dp.sv =====
// Datapath of the polyline simplifier: point store, span stack, keep flags,
// shared multiplier and result register. Depends on plsimp_pkg.
module plsimp_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  plsimp_pkg::t_point_in i_point,
    input  logic                  i_tol_we,
    input  logic [plsimp_pkg::TOL_W-1:0] i_tol_wdata,
    input  plsimp_pkg::t_op       i_op,
    output plsimp_pkg::t_status   o_status,
    output logic                  o_valid,
    output plsimp_pkg::t_kept_out o_kept
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int CWX = plsimp_pkg::COORD_W;
    localparam int DW = plsimp_pkg::DIFF_W;
    localparam int MW = plsimp_pkg::MUL_W;
    localparam int PW = plsimp_pkg::PROD_W;

    logic [2*CWX-1:0]      r_store [MAX_POINTS];
    logic [2*IW-1:0]       r_stack [MAX_POINTS];
    logic [MAX_POINTS-1:0] r_keep;
    logic [CW-1:0]         r_cnt, r_sp, r_at;
    logic                  r_ovf;
    logic [plsimp_pkg::TOL_W-1:0]  r_tol;
    logic [plsimp_pkg::TOL2_W-1:0] r_tol2;
    logic [IW-1:0]         r_s, r_e, r_best_at;
    logic [2*IW-1:0]       r_top;
    logic [2*CWX-1:0]      r_rd;
    logic signed [CWX-1:0] r_sx, r_sy;
    logic signed [DW-1:0]  r_dx, r_dy, r_ex, r_ey;
    logic signed [PW-1:0]  r_prod, r_acc;
    logic [PW-1:0]         r_best;
    logic                  r_degen, r_found, r_rv, r_pv, r_valid;
    logic [2*CWX-1:0]      r_pend;
    plsimp_pkg::t_kept_out r_out;

    logic signed [MW-1:0]  w_ma, w_mb;
    logic signed [CWX-1:0] w_rx, w_ry;
    logic [PW-1:0]         w_metric;
    logic                  w_rd_en;
    logic [IW-1:0]         w_rd_addr;
    logic [CW-1:0]         w_at_inc, w_s_inc;
    logic                  w_full, w_pass, w_more;

    assign w_rx     = r_rd[2*CWX-1:CWX];
    assign w_ry     = r_rd[CWX-1:0];
    assign w_full   = (r_cnt == CW'(MAX_POINTS));
    assign w_pass   = (r_cnt < CW'(plsimp_pkg::MIN_POINTS)) || (r_tol == '0);
    assign w_at_inc = r_at + CW'(1);
    assign w_s_inc  = CW'(r_s) + CW'(1);
    assign w_more   = (w_at_inc < CW'(r_e));
    assign w_metric = r_degen ? PW'(unsigned'(r_acc)) : PW'(unsigned'(r_prod));

    always_comb begin
        o_status.pass        = w_pass;
        o_status.stack_empty = (r_sp == '0);
        o_status.span_short  = (CW'(r_top[IW-1:0]) <= CW'(r_top[2*IW-1:IW]) + CW'(1));
        o_status.degen       = r_degen;
        o_status.more        = w_more;
        o_status.found       = r_found;
        o_status.scan_done   = (r_at == r_cnt) && !r_rv;
    end

    // Shared multiplier operand select.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_op)
            plsimp_pkg::OP_TSQ: begin
                w_ma = MW'(r_tol);
                w_mb = MW'(r_tol);
            end
            plsimp_pkg::OP_L1: begin
                w_ma = MW'(r_dx);
                w_mb = MW'(r_dx);
            end
            plsimp_pkg::OP_L2: begin
                w_ma = MW'(r_dy);
                w_mb = MW'(r_dy);
            end
            plsimp_pkg::OP_L4: begin
                w_ma = MW'(r_tol2);
                w_mb = r_acc[MW-1:0];
            end
            plsimp_pkg::OP_P1: begin
                w_ma = r_degen ? MW'(r_ex) : MW'(r_dy);
                w_mb = MW'(r_ex);
            end
            plsimp_pkg::OP_P2: begin
                w_ma = r_degen ? MW'(r_ey) : MW'(r_dx);
                w_mb = MW'(r_ey);
            end
            plsimp_pkg::OP_P4: begin
                w_ma = r_acc[MW-1:0];
                w_mb = r_acc[MW-1:0];
            end
            default: ;
        endcase
    end

    // Store read port select.
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_at[IW-1:0];
        case (i_op)
            plsimp_pkg::OP_SPAN: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_top[2*IW-1:IW];
            end
            plsimp_pkg::OP_RDS: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_e;
            end
            plsimp_pkg::OP_L5: begin
                w_rd_en   = 1'b1;
                w_rd_addr = w_s_inc[IW-1:0];
            end
            plsimp_pkg::OP_P5: begin
                w_rd_en   = w_more;
                w_rd_addr = w_at_inc[IW-1:0];
            end
            plsimp_pkg::OP_SCAN: begin
                w_rd_en   = (r_at < r_cnt) && r_keep[r_at[IW-1:0]];
                w_rd_addr = r_at[IW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd <= r_store[w_rd_addr];
        end
        if (i_op == plsimp_pkg::OP_LOAD && !w_full) begin
            r_store[r_cnt[IW-1:0]] <= {i_point.point_x, i_point.point_y};
        end
    end

    // Span stack: one write and one read port.
    always_ff @(posedge i_clk) begin
        if (i_op == plsimp_pkg::OP_POP && r_sp != '0) begin
            r_top <= r_stack[IW'(r_sp - CW'(1))];
        end
        if (i_op == plsimp_pkg::OP_INIT) begin
            r_stack[0] <= {IW'(0), IW'(r_cnt - CW'(1))};
        end else if (i_op == plsimp_pkg::OP_PUSH_LO && r_found && r_sp < CW'(MAX_POINTS)) begin
            r_stack[r_sp[IW-1:0]] <= {r_s, r_best_at};
        end else if (i_op == plsimp_pkg::OP_PUSH_HI && r_sp < CW'(MAX_POINTS)) begin
            r_stack[r_sp[IW-1:0]] <= {r_best_at, r_e};
        end
    end

    // Arithmetic and payload registers.
    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_ma) * PW'(w_mb);
        case (i_op)
            plsimp_pkg::OP_SPAN: begin
                r_s <= r_top[2*IW-1:IW];
                r_e <= r_top[IW-1:0];
            end
            plsimp_pkg::OP_RDS: begin
                r_sx <= w_rx;
                r_sy <= w_ry;
            end
            plsimp_pkg::OP_RDE: begin
                r_dx <= DW'(w_rx) - DW'(r_sx);
                r_dy <= DW'(w_ry) - DW'(r_sy);
            end
            plsimp_pkg::OP_TSQ: r_degen <= (r_dx == '0) && (r_dy == '0);
            plsimp_pkg::OP_L1:  r_tol2 <= r_prod[plsimp_pkg::TOL2_W-1:0];
            plsimp_pkg::OP_L2:  r_acc <= r_prod;
            plsimp_pkg::OP_L3:  r_acc <= r_acc + r_prod;
            plsimp_pkg::OP_L5:  r_best <= r_degen ? PW'(r_tol2) : PW'(unsigned'(r_prod));
            plsimp_pkg::OP_P0: begin
                r_ex <= DW'(w_rx) - DW'(r_sx);
                r_ey <= DW'(w_ry) - DW'(r_sy);
            end
            plsimp_pkg::OP_P2:  r_acc <= r_prod;
            plsimp_pkg::OP_P3:  r_acc <= r_degen ? r_acc + r_prod : r_acc - r_prod;
            plsimp_pkg::OP_P5: begin
                if (w_metric > r_best) begin
                    r_best    <= w_metric;
                    r_best_at <= r_at[IW-1:0];
                end
            end
            default: ;
        endcase
        if (i_op == plsimp_pkg::OP_SCAN && r_rv) begin
            r_pend <= r_rd;
        end
        r_out.kept_x      <= r_pend[2*CWX-1:CWX];
        r_out.kept_y      <= r_pend[CWX-1:0];
        r_out.final_point <= (i_op == plsimp_pkg::OP_FLUSH);
        r_out.overflowed  <= r_ovf;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_sp    <= '0;
            r_at    <= '0;
            r_ovf   <= 1'b0;
            r_tol   <= '0;
            r_keep  <= '0;
            r_found <= 1'b0;
            r_rv    <= 1'b0;
            r_pv    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_tol_we) begin
                r_tol <= i_tol_wdata;
            end
            case (i_op)
                plsimp_pkg::OP_LOAD: begin
                    if (w_full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                plsimp_pkg::OP_INIT: begin
                    r_at <= '0;
                    r_rv <= 1'b0;
                    r_pv <= 1'b0;
                    if (w_pass) begin
                        for (int i = 0; i < MAX_POINTS; i++) begin
                            r_keep[i] <= (CW'(i) < r_cnt);
                        end
                    end else begin
                        r_keep[0] <= 1'b1;
                        r_keep[IW'(r_cnt - CW'(1))] <= 1'b1;
                        r_sp <= CW'(1);
                    end
                end
                plsimp_pkg::OP_POP: begin
                    if (r_sp != '0) begin
                        r_sp <= r_sp - CW'(1);
                    end else begin
                        r_at <= '0;
                        r_rv <= 1'b0;
                    end
                end
                plsimp_pkg::OP_L5: begin
                    r_found <= 1'b0;
                    r_at    <= w_s_inc;
                end
                plsimp_pkg::OP_P5: begin
                    if (w_metric > r_best) begin
                        r_found <= 1'b1;
                    end
                    if (w_more) begin
                        r_at <= w_at_inc;
                    end
                end
                plsimp_pkg::OP_PUSH_LO: begin
                    if (r_found) begin
                        r_keep[r_best_at] <= 1'b1;
                        if (r_sp < CW'(MAX_POINTS)) begin
                            r_sp <= r_sp + CW'(1);
                        end
                    end
                end
                plsimp_pkg::OP_PUSH_HI: begin
                    if (r_sp < CW'(MAX_POINTS)) begin
                        r_sp <= r_sp + CW'(1);
                    end
                end
                plsimp_pkg::OP_SCAN: begin
                    // Hold one kept point back so the last one can be flagged.
                    if (r_at < r_cnt) begin
                        r_rv <= r_keep[r_at[IW-1:0]];
                        r_at <= w_at_inc;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (r_rv) begin
                        r_pv    <= 1'b1;
                        r_valid <= r_pv;
                    end
                end
                plsimp_pkg::OP_FLUSH: begin
                    r_valid <= 1'b1;
                    r_cnt   <= '0;
                    r_sp    <= '0;
                    r_ovf   <= 1'b0;
                    r_keep  <= '0;
                    r_pv    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_kept  = r_out;

`ifndef SYNTH
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(MAX_POINTS))
        else $error("span stack depth beyond capacity");
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == plsimp_pkg::OP_FLUSH) |=> (r_cnt == '0 && r_keep == '0 && r_valid))
        else $error("flush did not clear polyline state");
    a_scan_no_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == plsimp_pkg::OP_SCAN) |-> (r_sp == '0))
        else $error("emission started with spans pending");
`endif

endmodule

// ===== rtl/polyline_simplifier.sv =====
// Sequence: points load one per cycle while idle; after the last point an init step sets up the
// search, then each span is popped and its ends read; a span too short to split is dropped, else
// each interior point is tested (one more step when the chord has length, one shared multiplier)
// and a split pushes two spans. Emission: each kept point is strobed once the next is found.
// Throughput: one polyline at a time; busy stays high from the last point to the final word.
// Reset: synchronous active low; clears counts, keep flags, stack and tolerance.
// The receiver cannot stall: each result word is on o_kept for the single cycle of o_valid.
module polyline_simplifier #(
    parameter int MAX_POINTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  plsimp_pkg::t_point_in i_point,
    input  logic                  i_tol_we,
    input  logic [plsimp_pkg::TOL_W-1:0] i_tol_wdata,
    output logic                  o_valid,
    output plsimp_pkg::t_kept_out o_kept
);

    // Command and status between sequencer and datapath.
    plsimp_pkg::t_op     w_op;
    plsimp_pkg::t_status w_status;

    // Sequencer: accept words while idle, run the span stack, then emit.
    plsimp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_is_last (i_point.is_last),
        .i_status  (w_status),
        .o_op      (w_op),
        .o_busy    (busy)
    );

    // Datapath: store, stack, keep flags, squared-distance math, output register.
    plsimp_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_point     (i_point),
        .i_tol_we    (i_tol_we),
        .i_tol_wdata (i_tol_wdata),
        .i_op        (w_op),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .o_kept      (o_kept)
    );

endmodule
